FILE: rtl/core/log10_shift_add_fixed_point_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the log10 shift-add core
// Shared concurrent assertion forms, clocked on clk, reset on arst_n.
// ----------------------------------------------------------------------------
`ifndef LOG10_SHIFT_ADD_FIXED_POINT_CORE_DEFINES_SVH
`define LOG10_SHIFT_ADD_FIXED_POINT_CORE_DEFINES_SVH

// Checked outside reset only.
`define L10_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define L10_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/l10_pkg.sv
// ----------------------------------------------------------------------------
// l10_pkg
// Constants, tables and the stage type shared by the log10 core cells.
// ----------------------------------------------------------------------------
package l10_pkg;

	localparam int ROUNDS       = 8;
	localparam int FRAC_BITS    = 12;
	localparam int TABLE_FRAC   = 20;
	localparam int TABLE_ROUNDS = 12;
	localparam int N_ROUNDS     = (ROUNDS < TABLE_ROUNDS) ? ROUNDS : TABLE_ROUNDS;
	localparam int N_NORM       = 5;
	localparam int N_STAGES     = N_NORM + N_ROUNDS;
	localparam int TAB_SHIFT    = TABLE_FRAC - FRAC_BITS;

	localparam int X_W   = 24;
	localparam int OUT_W = 17;
	// accumulator magnitude stays below 2^(FRAC_BITS+4)
	localparam int ACC_W = (FRAC_BITS + 6 > OUT_W + 1) ? FRAC_BITS + 6 : OUT_W + 1;

	localparam int TAB_W = 23;
	localparam int NSH_W = 5;
	localparam int RSH_W = 4;

	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// log10(2^shift) * 2^20, truncated
	localparam logic [TAB_W-1:0] NORM_TAB [N_NORM] = '{
		23'd5050445, 23'd2525222, 23'd1262611, 23'd631305, 23'd315652
	};
	localparam logic [NSH_W-1:0] NORM_SHIFT [N_NORM] = '{
		5'd16, 5'd8, 5'd4, 5'd2, 5'd1
	};

	// log10(1 + 2^-(k+1)) * 2^20, truncated
	localparam logic [TAB_W-1:0] ALPHA_TAB [TABLE_ROUNDS] = '{
		23'd184645, 23'd101617, 23'd53637, 23'd27607, 23'd14013, 23'd7060,
		23'd3543,   23'd1775,   23'd888,   23'd444,   23'd222,   23'd111
	};

	typedef struct packed {
		logic                    vld;
		logic [X_W-1:0]          x;
		logic signed [ACC_W-1:0] acc;
	} l10_stage_t;

	function automatic logic signed [ACC_W-1:0] scaled(logic [TAB_W-1:0] v);
		logic [TAB_W-1:0] s;
		s = v >> TAB_SHIFT;
		return $signed(ACC_W'(s));
	endfunction

endpackage

FILE: rtl/core/l10_norm_cell.sv
// ----------------------------------------------------------------------------
// l10_norm_cell
// One leading-zero normalization cell: shift left if the top bits are clear.
// ----------------------------------------------------------------------------
module l10_norm_cell (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic [l10_pkg::NSH_W-1:0]                 shift,
	input  logic signed [l10_pkg::ACC_W-1:0]          sub,
	input  l10_pkg::l10_stage_t                       d_in,
	output l10_pkg::l10_stage_t                       d_out
);

	logic [l10_pkg::X_W-1:0]          top_mask;
	logic                             hit;
	logic                             vld_q;
	logic [l10_pkg::X_W-1:0]          x_q;
	logic signed [l10_pkg::ACC_W-1:0] acc_q;

	assign top_mask = ~({l10_pkg::X_W{1'b1}} >> shift);
	assign hit      = (d_in.x & top_mask) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= hit ? (d_in.x << shift) : d_in.x;
			acc_q <= hit ? (d_in.acc - sub) : d_in.acc;
		end
	end

	assign d_out.vld = vld_q;
	assign d_out.x   = x_q;
	assign d_out.acc = acc_q;

endmodule

FILE: rtl/core/l10_round_cell.sv
// ----------------------------------------------------------------------------
// l10_round_cell
// One shift-add round: keep x + (x >> shift) when it stays below 2^24.
// ----------------------------------------------------------------------------
module l10_round_cell (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic [l10_pkg::RSH_W-1:0]                 shift,
	input  logic signed [l10_pkg::ACC_W-1:0]          sub,
	input  l10_pkg::l10_stage_t                       d_in,
	output l10_pkg::l10_stage_t                       d_out
);

	logic [l10_pkg::X_W:0]            t;
	logic                             keep;
	logic                             vld_q;
	logic [l10_pkg::X_W-1:0]          x_q;
	logic signed [l10_pkg::ACC_W-1:0] acc_q;

	assign t    = {1'b0, d_in.x} + ({1'b0, d_in.x} >> shift);
	assign keep = ~t[l10_pkg::X_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= keep ? t[l10_pkg::X_W-1:0] : d_in.x;
			acc_q <= keep ? (d_in.acc - sub) : d_in.acc;
		end
	end

	assign d_out.vld = vld_q;
	assign d_out.x   = x_q;
	assign d_out.acc = acc_q;

endmodule

FILE: rtl/core/log10_shift_add_fixed_point_core.sv
// ----------------------------------------------------------------------------
// log10_shift_add_fixed_point_core
// Pipelined base-10 logarithm of a 24-bit unsigned fraction.
// ----------------------------------------------------------------------------
// Takes sample/2^24 and returns log10 of it in two's complement with 12
// fraction bits (zero input gives -39756, full scale gives 0). The data path
// is a chain of 13 registered cells, five normalization cells followed by
// eight shift-add rounds, then one output register, and one request is
// taken on the sample side every cycle unless stalled. The whole chain
// advances together and stalls only while a finished result sits in the
// output register and log_ready is low, so sample_ready follows
// (!log_valid || log_ready).
module log10_shift_add_fixed_point_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [l10_pkg::X_W-1:0]           sample,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	output logic signed [l10_pkg::OUT_W-1:0]  log_value,
	output logic                              log_valid,
	input  logic                              log_ready
);

	// chain[0] is the input side, chain[N_STAGES] leaves the last cell
	l10_pkg::l10_stage_t chain [l10_pkg::N_STAGES+1];

	logic                              en;
	logic                              out_vld_q;
	logic [l10_pkg::OUT_W-1:0]         out_val_q;
	logic signed [l10_pkg::ACC_W-1:0]  acc_last;
	logic [l10_pkg::OUT_W-1:0]         sat_val;

	// Global advance: move whenever the output slot is empty or being drained.
	assign en           = !out_vld_q || log_ready;
	assign sample_ready = en;

	assign chain[0].vld = sample_valid;
	assign chain[0].x   = sample;
	assign chain[0].acc = '0;

	// Normalization cells: shift 16, 8, 4, 2, 1 when those top bits are zero.
	for (genvar i = 0; i < l10_pkg::N_NORM; i++) begin : g_norm
		l10_norm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shift  (l10_pkg::NORM_SHIFT[i]),
			.sub    (l10_pkg::scaled(l10_pkg::NORM_TAB[i])),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	// Shift-add rounds: round k tries x + (x >> (k+1)).
	for (genvar k = 0; k < l10_pkg::N_ROUNDS; k++) begin : g_round
		l10_round_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shift  (l10_pkg::RSH_W'(k + 1)),
			.sub    (l10_pkg::scaled(l10_pkg::ALPHA_TAB[k])),
			.d_in   (chain[l10_pkg::N_NORM+k]),
			.d_out  (chain[l10_pkg::N_NORM+k+1])
		);
	end

	// Saturate to the most negative 17-bit code if the sum runs past it
	// (only reachable with a larger FRAC_BITS).
	assign acc_last = chain[l10_pkg::N_STAGES].acc;
	always_comb begin
		if (acc_last < $signed({{(l10_pkg::ACC_W-l10_pkg::OUT_W){1'b1}}, l10_pkg::OUT_MIN}))
			sat_val = l10_pkg::OUT_MIN;
		else
			sat_val = acc_last[l10_pkg::OUT_W-1:0];
	end

	// Output register: holds a result until log_ready takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[l10_pkg::N_STAGES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= sat_val;
		end
	end

	assign log_valid = out_vld_q;
	assign log_value = $signed(out_val_q);

endmodule

FILE: rtl/core/l10_chk.sv
// ----------------------------------------------------------------------------
// l10_chk
// Port-level checks for the log10 core, bound to the top level.
// ----------------------------------------------------------------------------
`include "log10_shift_add_fixed_point_core_defines.svh"

module l10_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic [l10_pkg::X_W-1:0]           sample,
	input logic                              sample_valid,
	input logic                              sample_ready,
	input logic signed [l10_pkg::OUT_W-1:0]  log_value,
	input logic                              log_valid,
	input logic                              log_ready
);

	// no result may show while reset is applied
	`L10_ASSERT_ALWAYS(a_rst_no_valid, (!arst_n |-> !log_valid), "log_valid high in reset")

	// a stalled result holds
	`L10_ASSERT(a_hold, (log_valid && !log_ready |=> log_valid && $stable(log_value)), "result changed while stalled")

	// logarithm of a fraction is never positive
	`L10_ASSERT(a_nonpos, (log_valid |-> log_value[l10_pkg::OUT_W-1] || log_value == '0), "positive result")

	// empty output slot means the chain can take a request
	`L10_ASSERT(a_ready_empty, (!log_valid |-> sample_ready), "not ready with empty output")

	// draining the output frees the input side in the same cycle
	`L10_ASSERT(a_ready_drain, (log_valid && log_ready |-> sample_ready), "not ready while draining")

endmodule

bind log10_shift_add_fixed_point_core l10_chk u_l10_chk (.*);
